>>> sv/pcbs_pkg.sv
// Package for per-class box suppression: controller states and fixed constants.
// No dependencies.
`default_nettype none
package pcbs_pkg;

    localparam int unsigned COORD_W  = 16;
    localparam int unsigned SCORE_W  = 16;
    localparam int unsigned CLASS_W  = 7;
    localparam int unsigned THR_W    = 8;
    localparam logic [THR_W-1:0] THR_RESET = 8'd128;
    // one pixel in Q12.4
    localparam logic signed [17:0] ONE_PIXEL = 18'sd16;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b000000000001,
        ST_SEL_RD  = 12'b000000000010,
        ST_SEL_CMP = 12'b000000000100,
        ST_GET     = 12'b000000001000,
        ST_GET2    = 12'b000000010000,
        ST_CK_RD   = 12'b000000100000,
        ST_CK_S1   = 12'b000001000000,
        ST_CK_S2   = 12'b000010000000,
        ST_CK_S3   = 12'b000100000000,
        ST_CK_S4   = 12'b001000000000,
        ST_KEEP    = 12'b010000000000,
        ST_FIN     = 12'b100000000000
    } pcbs_state_t;

endpackage
`default_nettype wire

>>> sv/per_class_box_suppression_top.sv
// Channel      | handshake          | payload
// candidate in | start / busy       | box_x1..box_y2, objectness, class_score, class_id, last_box
// result out   | done (strobe)      | kept_x1..kept_y2, kept_objectness, kept_class_score,
//              |                    | kept_class_id, last_kept, overflow
// threshold    | cfg_we             | cfg_wdata
//
// A candidate without last_box is only stored. On last_box the block picks boxes in walk
// order by a selection scan over the score memory, then checks the pick against the kept boxes
// in the kept memory until one suppresses it; the overlap is computed only on a class match.
// Reset clears control only; memories need no clearing. Results cannot be stalled.
// Per-class greedy box suppression: top level, depends on pcbs_pkg.
`default_nettype none
module per_class_box_suppression_top
    import pcbs_pkg::*;
#(
    parameter int unsigned MAX_DETS      = 64,
    parameter int unsigned CLASS_ID_BITS = 7
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic signed [COORD_W-1:0] box_x1,
    input  wire logic signed [COORD_W-1:0] box_y1,
    input  wire logic signed [COORD_W-1:0] box_x2,
    input  wire logic signed [COORD_W-1:0] box_y2,
    input  wire logic [SCORE_W-1:0]        objectness,
    input  wire logic [SCORE_W-1:0]        class_score,
    input  wire logic [CLASS_W-1:0]        class_id,
    input  wire logic                      last_box,
    input  wire logic                      cfg_we,
    input  wire logic [THR_W-1:0]          cfg_wdata,
    output logic                           done,
    output logic signed [COORD_W-1:0]      kept_x1,
    output logic signed [COORD_W-1:0]      kept_y1,
    output logic signed [COORD_W-1:0]      kept_x2,
    output logic signed [COORD_W-1:0]      kept_y2,
    output logic [SCORE_W-1:0]             kept_objectness,
    output logic [SCORE_W-1:0]             kept_class_score,
    output logic [CLASS_W-1:0]             kept_class_id,
    output logic                           last_kept,
    output logic                           overflow
);

    localparam int unsigned CW   = (CLASS_ID_BITS < CLASS_W) ? CLASS_ID_BITS : CLASS_W;
    localparam int unsigned AW   = $clog2(MAX_DETS);
    localparam int unsigned CNTW = $clog2(MAX_DETS + 1);
    localparam int unsigned BW   = 4 * COORD_W;
    localparam int unsigned SW   = 2 * SCORE_W + CW;
    localparam int unsigned KW   = BW + CW;

    pcbs_state_t state_reg, state_next;

    logic [BW-1:0] box_mem   [MAX_DETS];
    logic [SW-1:0] score_mem [MAX_DETS];
    logic [KW-1:0] kept_mem  [MAX_DETS];
    logic [BW-1:0] box_q;
    logic [SW-1:0] score_q;
    logic [KW-1:0] kept_q;

    logic [THR_W-1:0]   thr_reg;
    logic [CNTW-1:0]    count_reg, scan_reg, kcnt_reg, k_reg;
    logic               ovf_reg;
    logic [MAX_DETS-1:0] done_reg;
    logic               found_reg;
    logic [AW-1:0]      best_reg;
    logic [CW-1:0]      best_cls_reg;
    logic [SCORE_W-1:0] best_obj_reg, best_cs_reg;
    logic [BW-1:0]      cand_box_reg;
    logic               pend_valid_reg;
    logic [BW-1:0]      pend_box_reg;
    logic [SCORE_W-1:0] pend_obj_reg, pend_cs_reg;
    logic [CW-1:0]      pend_cls_reg;

    logic [16:0]        iw_reg, ih_reg;
    logic signed [17:0] awx_reg, awy_reg, bwx_reg, bwy_reg;
    logic [33:0]        inter_reg;
    logic signed [35:0] aarea_reg, barea_reg;
    logic signed [37:0] uni_reg;

    logic               out_valid_reg, last_reg, ovf_out_reg;
    logic [BW-1:0]      out_box_reg;
    logic [SCORE_W-1:0] out_obj_reg, out_cs_reg;
    logic [CW-1:0]      out_cls_reg;

    logic accept, store_ok;
    assign accept   = start && (state_reg == ST_IDLE) && !out_valid_reg;
    assign store_ok = (count_reg < CNTW'(MAX_DETS));

    // selection scan compare
    logic [AW-1:0]      scan_idx;
    logic [SCORE_W-1:0] sc_obj;
    logic [CW-1:0]      sc_cls;
    logic               better, found_next, scan_end;
    assign scan_idx = scan_reg[AW-1:0];
    assign sc_obj   = score_q[SCORE_W-1:0];
    assign sc_cls   = score_q[SW-1:2*SCORE_W];
    assign better   = !done_reg[scan_idx] &&
                      (!found_reg || (sc_cls < best_cls_reg) ||
                       ((sc_cls == best_cls_reg) && (sc_obj > best_obj_reg)));
    assign found_next = found_reg || better;
    assign scan_end   = ((scan_reg + 1'b1) == count_reg);

    // overlap geometry, a = kept box, b = candidate
    logic signed [COORD_W-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic signed [COORD_W-1:0] mx1, my1, mx2, my2;
    logic signed [17:0]        iw_s, ih_s;
    logic                      cls_match, k_end, suppress;
    logic [44:0]               lhs, rhs;
    assign ax1 = kept_q[15:0];
    assign ay1 = kept_q[31:16];
    assign ax2 = kept_q[47:32];
    assign ay2 = kept_q[63:48];
    assign bx1 = cand_box_reg[15:0];
    assign by1 = cand_box_reg[31:16];
    assign bx2 = cand_box_reg[47:32];
    assign by2 = cand_box_reg[63:48];
    assign mx1 = (ax1 > bx1) ? ax1 : bx1;
    assign my1 = (ay1 > by1) ? ay1 : by1;
    assign mx2 = (ax2 < bx2) ? ax2 : bx2;
    assign my2 = (ay2 < by2) ? ay2 : by2;
    assign iw_s = 18'(mx2) - 18'(mx1) + ONE_PIXEL;
    assign ih_s = 18'(my2) - 18'(my1) + ONE_PIXEL;
    assign cls_match = (kept_q[KW-1:BW] == best_cls_reg);
    assign k_end     = ((k_reg + 1'b1) == kcnt_reg);
    assign lhs = 45'({inter_reg, 8'h00});
    assign rhs = 45'(thr_reg) * 45'(uni_reg[36:0]);
    assign suppress = (uni_reg > 38'sd0) && (lhs >= rhs);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (accept && last_box) state_next = ST_SEL_RD;
            ST_SEL_RD:  state_next = ST_SEL_CMP;
            ST_SEL_CMP:
            begin
                if (scan_end) state_next = found_next ? ST_GET : ST_FIN;
                else          state_next = ST_SEL_RD;
            end
            ST_GET:     state_next = ST_GET2;
            ST_GET2:    state_next = (kcnt_reg == '0) ? ST_KEEP : ST_CK_RD;
            ST_CK_RD:   state_next = ST_CK_S1;
            ST_CK_S1:
            begin
                if (cls_match) state_next = ST_CK_S2;
                else           state_next = k_end ? ST_KEEP : ST_CK_RD;
            end
            ST_CK_S2:   state_next = ST_CK_S3;
            ST_CK_S3:   state_next = ST_CK_S4;
            ST_CK_S4:
            begin
                if (suppress)   state_next = ST_SEL_RD;
                else            state_next = k_end ? ST_KEEP : ST_CK_RD;
            end
            ST_KEEP:    state_next = ST_SEL_RD;
            ST_FIN:     state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
        begin
            box_mem[count_reg[AW-1:0]]   <= {box_y2, box_x2, box_y1, box_x1};
            score_mem[count_reg[AW-1:0]] <= {class_id[CW-1:0], class_score, objectness};
        end
        if (state_reg == ST_KEEP)
            kept_mem[kcnt_reg[AW-1:0]] <= {best_cls_reg, cand_box_reg};
        box_q   <= box_mem[best_reg];
        score_q <= score_mem[scan_idx];
        kept_q  <= kept_mem[k_reg[AW-1:0]];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SEL_CMP && better)
        begin
            best_reg     <= scan_idx;
            best_cls_reg <= sc_cls;
            best_obj_reg <= sc_obj;
            best_cs_reg  <= score_q[2*SCORE_W-1:SCORE_W];
        end
        if (state_reg == ST_GET2)
            cand_box_reg <= box_q;
        if (state_reg == ST_CK_S1)
        begin
            iw_reg  <= iw_s[17] ? 17'd0 : iw_s[16:0];
            ih_reg  <= ih_s[17] ? 17'd0 : ih_s[16:0];
            awx_reg <= 18'(ax2) - 18'(ax1) + ONE_PIXEL;
            awy_reg <= 18'(ay2) - 18'(ay1) + ONE_PIXEL;
            bwx_reg <= 18'(bx2) - 18'(bx1) + ONE_PIXEL;
            bwy_reg <= 18'(by2) - 18'(by1) + ONE_PIXEL;
        end
        if (state_reg == ST_CK_S2)
        begin
            inter_reg <= iw_reg * ih_reg;
            aarea_reg <= awx_reg * awy_reg;
            barea_reg <= bwx_reg * bwy_reg;
        end
        if (state_reg == ST_CK_S3)
            uni_reg <= 38'(aarea_reg) + 38'(barea_reg) - $signed({4'b0000, inter_reg});
        if (state_reg == ST_KEEP)
        begin
            pend_box_reg <= cand_box_reg;
            pend_obj_reg <= best_obj_reg;
            pend_cs_reg  <= best_cs_reg;
            pend_cls_reg <= best_cls_reg;
        end
        if ((state_reg == ST_KEEP || state_reg == ST_FIN) && pend_valid_reg)
        begin
            out_box_reg <= pend_box_reg;
            out_obj_reg <= pend_obj_reg;
            out_cs_reg  <= pend_cs_reg;
            out_cls_reg <= pend_cls_reg;
            ovf_out_reg <= ovf_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= THR_RESET;
            count_reg      <= '0;
            scan_reg       <= '0;
            kcnt_reg       <= '0;
            k_reg          <= '0;
            ovf_reg        <= 1'b0;
            done_reg       <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
            if (cfg_we)
                thr_reg <= cfg_wdata;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (store_ok) count_reg <= count_reg + 1'b1;
                        else          ovf_reg   <= 1'b1;
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                        kcnt_reg  <= '0;
                    end
                end
                ST_SEL_CMP:
                begin
                    scan_reg  <= scan_reg + 1'b1;
                    found_reg <= found_next;
                end
                ST_GET2:
                begin
                    done_reg[best_reg] <= 1'b1;
                    k_reg              <= '0;
                end
                ST_CK_S1:
                    if (!cls_match) k_reg <= k_reg + 1'b1;
                ST_CK_S4:
                begin
                    // drop the candidate and rescan
                    if (suppress)
                    begin
                        scan_reg  <= '0;
                        found_reg <= 1'b0;
                    end
                    else
                        k_reg <= k_reg + 1'b1;
                end
                ST_KEEP:
                begin
                    kcnt_reg       <= kcnt_reg + 1'b1;
                    out_valid_reg  <= pend_valid_reg;
                    pend_valid_reg <= 1'b1;
                    scan_reg       <= '0;
                    found_reg      <= 1'b0;
                end
                ST_FIN:
                begin
                    out_valid_reg  <= pend_valid_reg;
                    last_reg       <= pend_valid_reg;
                    pend_valid_reg <= 1'b0;
                    count_reg      <= '0;
                    kcnt_reg       <= '0;
                    ovf_reg        <= 1'b0;
                    done_reg       <= '0;
                end
                default: ;
            endcase
        end
    end

    assign busy             = (state_reg != ST_IDLE) || out_valid_reg;
    assign done             = out_valid_reg;
    assign kept_x1          = out_box_reg[15:0];
    assign kept_y1          = out_box_reg[31:16];
    assign kept_x2          = out_box_reg[47:32];
    assign kept_y2          = out_box_reg[63:48];
    assign kept_objectness  = out_obj_reg;
    assign kept_class_score = out_cs_reg;
    assign kept_class_id    = CLASS_W'(out_cls_reg);
    assign last_kept        = last_reg;
    assign overflow         = ovf_out_reg;

endmodule
`default_nettype wire

>>> sv/pcbs_checker.sv
// Port-level checks for per-class box suppression, bound to the top level.
// Depends on per_class_box_suppression_top ports only.
`default_nettype none
module pcbs_port_checks (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic last_box,
    input wire logic done,
    input wire logic last_kept
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result word while not busy");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        last_kept |-> done)
        else $error("last flag without result word");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (done && last_kept) |=> !done)
        else $error("result word after last of frame");

    a_nonlast_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last_box) |=> (!done && !busy))
        else $error("non-last candidate produced activity");

endmodule

bind per_class_box_suppression_top pcbs_port_checks u_pcbs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .last_box  (last_box),
    .done      (done),
    .last_kept (last_kept)
);
`default_nettype wire

>>> sim/pcbs_checker.sv
// Checker for per-class box suppression: watches the candidate, threshold and result
// channels, predicts the kept boxes of each frame and compares them. Depends on pcbs_pkg.
`timescale 1ns / 100ps
module pcbs_checker
    import pcbs_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic                      busy,
    input  wire logic signed [COORD_W-1:0] box_x1,
    input  wire logic signed [COORD_W-1:0] box_y1,
    input  wire logic signed [COORD_W-1:0] box_x2,
    input  wire logic signed [COORD_W-1:0] box_y2,
    input  wire logic [SCORE_W-1:0]        objectness,
    input  wire logic [SCORE_W-1:0]        class_score,
    input  wire logic [CLASS_W-1:0]        class_id,
    input  wire logic                      last_box,
    input  wire logic                      cfg_we,
    input  wire logic [THR_W-1:0]          cfg_wdata,
    input  wire logic                      done,
    input  wire logic signed [COORD_W-1:0] kept_x1,
    input  wire logic signed [COORD_W-1:0] kept_y1,
    input  wire logic signed [COORD_W-1:0] kept_x2,
    input  wire logic signed [COORD_W-1:0] kept_y2,
    input  wire logic [SCORE_W-1:0]        kept_objectness,
    input  wire logic [SCORE_W-1:0]        kept_class_score,
    input  wire logic [CLASS_W-1:0]        kept_class_id,
    input  wire logic                      last_kept,
    input  wire logic                      overflow,
    output int                             fail_count,
    output int                             pending
);

    localparam int unsigned DEPTH = 64;

    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic [SCORE_W-1:0]        obj;
        logic [SCORE_W-1:0]        cscore;
        logic [CLASS_W-1:0]        cls;
    } cand_t;

    typedef struct packed {
        cand_t box;
        logic  last;
        logic  ovf;
    } kept_t;

    cand_t       held [DEPTH];
    int unsigned held_n;
    bit          dropped;
    logic [THR_W-1:0] thr;
    kept_t       kept_q [$];

    assign pending = kept_q.size();

    function automatic longint side(longint lo, longint hi);
        return hi - lo + 16;
    endfunction

    // true when box b is suppressed by kept box a
    function automatic bit suppresses(cand_t a, cand_t b, logic [THR_W-1:0] t);
        longint iw, ih, inter, uni;
        iw = side(a.x1 > b.x1 ? a.x1 : b.x1, a.x2 < b.x2 ? a.x2 : b.x2);
        ih = side(a.y1 > b.y1 ? a.y1 : b.y1, a.y2 < b.y2 ? a.y2 : b.y2);
        if (iw < 0) iw = 0;
        if (ih < 0) ih = 0;
        inter = iw * ih;
        uni = side(a.x1, a.x2) * side(a.y1, a.y2) + side(b.x1, b.x2) * side(b.y1, b.y2) - inter;
        if (uni <= 0) return 1'b0;
        return inter * 256 >= longint'(t) * uni;
    endfunction

    task automatic suppress_frame();
        int unsigned order [DEPTH];
        bit          keep [DEPTH];
        int unsigned i, j, v, kept_n, emitted;
        kept_t       r;
        kept_n = 0;
        emitted = 0;
        // stable sort: class ascending, objectness descending
        for (i = 0; i < held_n; i++) begin
            v = i;
            j = i;
            while (j > 0 && (held[v].cls < held[order[j-1]].cls ||
                   (held[v].cls == held[order[j-1]].cls && held[v].obj > held[order[j-1]].obj)))
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = v;
        end
        for (i = 0; i < held_n; i++) begin
            keep[order[i]] = 1'b1;
            for (j = 0; j < i && keep[order[i]]; j++) begin
                if (keep[order[j]] && held[order[j]].cls == held[order[i]].cls &&
                    suppresses(held[order[j]], held[order[i]], thr))
                    keep[order[i]] = 1'b0;
            end
            if (keep[order[i]]) kept_n++;
        end
        for (i = 0; i < held_n; i++) begin
            if (keep[order[i]]) begin
                emitted++;
                r.box  = held[order[i]];
                r.last = (emitted == kept_n);
                r.ovf  = dropped;
                kept_q = {kept_q, r};
            end
        end
    endtask

    function automatic int field_bad(string name, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        kept_t w;
        int    bad;
        if (!rst_n) begin
            thr        <= THR_RESET;
            held_n     = 0;
            dropped    = 1'b0;
            fail_count <= 0;
        end
        else begin
            if (cfg_we) thr <= cfg_wdata;
            if (start && !busy) begin
                if (held_n < DEPTH) begin
                    held[held_n] = '{box_x1, box_y1, box_x2, box_y2, objectness,
                                     class_score, class_id};
                    held_n++;
                end
                else dropped = 1'b1;
                if (last_box) begin
                    suppress_frame();
                    held_n  = 0;
                    dropped = 1'b0;
                end
            end
            if (done) begin
                if (kept_q.size() == 0) begin
                    $display("%0t: unexpected word: expected none, got box class %0d",
                             $time, kept_class_id);
                    fail_count <= fail_count + 1;
                end
                else begin
                    w = kept_q.pop_front();
                    bad = field_bad("kept_x1", w.box.x1, kept_x1)
                        + field_bad("kept_y1", w.box.y1, kept_y1)
                        + field_bad("kept_x2", w.box.x2, kept_x2)
                        + field_bad("kept_y2", w.box.y2, kept_y2)
                        + field_bad("kept_objectness", w.box.obj, kept_objectness)
                        + field_bad("kept_class_score", w.box.cscore, kept_class_score)
                        + field_bad("kept_class_id", w.box.cls, kept_class_id)
                        + field_bad("last_kept", w.last, last_kept)
                        + field_bad("overflow", w.ovf, overflow);
                    if (bad != 0) fail_count <= fail_count + 1;
                end
            end
        end
    end

endmodule

>>> sim/per_class_box_suppression_top_tb.sv
// Testbench top for per-class box suppression: drives candidate frames and threshold
// writes, gives the verdict. Depends on pcbs_pkg, pcbs_checker and the block.
`timescale 1ns / 100ps
module per_class_box_suppression_top_tb;
    import pcbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [COORD_W-1:0] box_x1 = '0, box_y1 = '0, box_x2 = '0, box_y2 = '0;
    logic [SCORE_W-1:0] objectness = '0, class_score = '0;
    logic [CLASS_W-1:0] class_id = '0;
    logic last_box = 1'b0;
    logic cfg_we = 1'b0;
    logic [THR_W-1:0] cfg_wdata = '0;
    logic done, last_kept, overflow;
    logic signed [COORD_W-1:0] kept_x1, kept_y1, kept_x2, kept_y2;
    logic [SCORE_W-1:0] kept_objectness, kept_class_score;
    logic [CLASS_W-1:0] kept_class_id;
    int fail_count, pending;
    int idle_pct = 0;
    int sent = 0;
    int quiet_cycles = 0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    per_class_box_suppression_top i_dut (
        .clk, .rst_n, .start, .busy,
        .box_x1, .box_y1, .box_x2, .box_y2, .objectness, .class_score, .class_id, .last_box,
        .cfg_we, .cfg_wdata, .done,
        .kept_x1, .kept_y1, .kept_x2, .kept_y2, .kept_objectness, .kept_class_score,
        .kept_class_id, .last_kept, .overflow
    );

    pcbs_checker i_checker (
        .clk, .rst_n, .start, .busy,
        .box_x1, .box_y1, .box_x2, .box_y2, .objectness, .class_score, .class_id, .last_box,
        .cfg_we, .cfg_wdata, .done,
        .kept_x1, .kept_y1, .kept_x2, .kept_y2, .kept_objectness, .kept_class_score,
        .kept_class_id, .last_kept, .overflow,
        .fail_count, .pending
    );

    // count cycles in which nothing moves
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // called and returns at a falling edge; start stays high for a following word
    task automatic put_box(int x1, int y1, int x2, int y2, int obj, int cs, int cls, bit last);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        box_x1      <= x1[15:0];
        box_y1      <= y1[15:0];
        box_x2      <= x2[15:0];
        box_y2      <= y2[15:0];
        objectness  <= obj[15:0];
        class_score <= cs[15:0];
        class_id    <= cls[6:0];
        last_box    <= last;
        forever
        begin
            @(posedge clk);
            if (!busy) break;
        end
        @(negedge clk);
        sent++;
    endtask

    // hold off until every kept box has come out and the block has settled
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic set_threshold(int t);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= t[7:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_frame(int n);
        int bx, by, bw, bh, cls_base, cls_span, jit, k, c, x1, y1;
        bit noise;
        noise    = ($urandom_range(99) < 15);
        cls_base = $urandom_range(0, 120);
        cls_span = $urandom_range(0, 3);
        bx = $urandom_range(0, 8000) - 4000;
        by = $urandom_range(0, 8000) - 4000;
        bw = $urandom_range(16, 1200);
        bh = $urandom_range(16, 1200);
        jit = $urandom_range(0, 3) * 64;
        for (k = 0; k < n; k++)
        begin
            c = cls_base + $urandom_range(0, cls_span);
            if (noise || $urandom_range(99) < 5)
                put_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom_range(0, 127), k == n - 1);
            else
            begin
                x1 = bx + $urandom_range(0, 2 * jit) - jit;
                y1 = by + $urandom_range(0, 2 * jit) - jit;
                // coarse objectness gives frequent ties
                put_box(x1, y1, x1 + bw + $urandom_range(0, jit), y1 + bh + $urandom_range(0, jit),
                        $urandom_range(0, 7) * 8192 + ($urandom_range(0, 1) ? 0 : $urandom_range(0, 8191)),
                        $urandom, c, k == n - 1);
            end
        end
    endtask

    initial
    begin
        int k, phase;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // default threshold: extreme values in single-box frames
        put_box(-32768, -32768, 32767, 32767, 65535, 65535, 127, 1'b1);
        put_box(32767, 32767, -32768, -32768, 0, 0, 0, 1'b1);
        // duplicate suppression, edge at zero, reversed box, objectness tie
        put_box(0, 0, 320, 320, 100, 1, 0, 1'b0);
        put_box(0, 0, 320, 320, 200, 2, 0, 1'b0);
        put_box(0, 16, 480, 160, 300, 3, 1, 1'b0);
        put_box(320, 320, 0, 0, 400, 4, 0, 1'b0);
        put_box(1000, 1000, 1100, 1100, 500, 5, 2, 1'b0);
        put_box(2000, 2000, 2100, 2100, 500, 6, 2, 1'b0);
        put_box(1000, 1000, 1100, 1100, 400, 7, 2, 1'b1);

        // zero threshold: any positive union suppresses
        set_threshold(0);
        put_box(-32768, -32768, -32000, -32000, 10, 8, 5, 1'b0);
        put_box(100, 100, 200, 200, 20, 9, 5, 1'b0);
        put_box(300, 300, 290, 290, 30, 10, 5, 1'b0);
        put_box(5, 5, 6, 6, 30, 11, 6, 1'b1);

        // full threshold: only near-identical boxes suppress
        set_threshold(255);
        put_box(0, 0, 640, 640, 900, 12, 3, 1'b0);
        put_box(0, 0, 640, 640, 800, 13, 3, 1'b0);
        put_box(16, 0, 640, 640, 700, 14, 3, 1'b0);
        put_box(0, 0, 640, 640, 800, 15, 4, 1'b1);

        // store overflow: the last candidate itself is dropped
        set_threshold(128);
        for (k = 0; k < 66; k++)
            put_box($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 3), $urandom,
                    $urandom_range(0, 1), k == 65);
        put_box(0, 0, 16, 16, 1, 1, 9, 1'b1);

        phase = 0;
        while (sent < 110)
        begin
            case (phase % 4)
                0: idle_pct = 0;
                1: idle_pct = 87;
                2: idle_pct = 29;
                default: idle_pct = 0;
            endcase
            if (phase % 3 == 2)
                set_threshold($urandom_range(0, 3) == 0 ? 255 * $urandom_range(0, 1) :
                              $urandom_range(0, 255));
            else if (phase == 5)
                drain();
            random_frame($urandom_range(0, 9) == 0 ? $urandom_range(10, 24) :
                         $urandom_range(1, 8));
            phase++;
        end

        drain();
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
